>>> sv/integer_to_roman_numeral_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define I2R_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The antecedent implies the consequent in the next cycle.
`define I2R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> sv/i2r_pkg.sv
package i2r_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned SymW    = 7;
  localparam int unsigned WeightW = 10;
  localparam int unsigned PcW     = 4;

  localparam logic [SymW-1:0] CharNone = 7'h00;
  localparam logic [SymW-1:0] CharI    = 7'h49;
  localparam logic [SymW-1:0] CharV    = 7'h56;
  localparam logic [SymW-1:0] CharX    = 7'h58;
  localparam logic [SymW-1:0] CharL    = 7'h4C;
  localparam logic [SymW-1:0] CharC    = 7'h43;
  localparam logic [SymW-1:0] CharD    = 7'h44;
  localparam logic [SymW-1:0] CharM    = 7'h4D;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [SymW-1:0]    sym_a;
    logic [SymW-1:0]    sym_b;
    logic               pair;
    logic               rep;
  } ucode_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            is_empty;
    logic            last;
  } char_t;

  function automatic ucode_t i2r_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{weight: 10'd1000, sym_a: CharM, sym_b: CharNone, pair: 1'b0, rep: 1'b1};
      4'd1:    w = '{weight: 10'd900,  sym_a: CharC, sym_b: CharM,    pair: 1'b1, rep: 1'b0};
      4'd2:    w = '{weight: 10'd500,  sym_a: CharD, sym_b: CharNone, pair: 1'b0, rep: 1'b0};
      4'd3:    w = '{weight: 10'd400,  sym_a: CharC, sym_b: CharD,    pair: 1'b1, rep: 1'b0};
      4'd4:    w = '{weight: 10'd100,  sym_a: CharC, sym_b: CharNone, pair: 1'b0, rep: 1'b1};
      4'd5:    w = '{weight: 10'd90,   sym_a: CharX, sym_b: CharC,    pair: 1'b1, rep: 1'b0};
      4'd6:    w = '{weight: 10'd50,   sym_a: CharL, sym_b: CharNone, pair: 1'b0, rep: 1'b0};
      4'd7:    w = '{weight: 10'd40,   sym_a: CharX, sym_b: CharL,    pair: 1'b1, rep: 1'b0};
      4'd8:    w = '{weight: 10'd10,   sym_a: CharX, sym_b: CharNone, pair: 1'b0, rep: 1'b1};
      4'd9:    w = '{weight: 10'd9,    sym_a: CharI, sym_b: CharX,    pair: 1'b1, rep: 1'b0};
      4'd10:   w = '{weight: 10'd5,    sym_a: CharV, sym_b: CharNone, pair: 1'b0, rep: 1'b0};
      4'd11:   w = '{weight: 10'd4,    sym_a: CharI, sym_b: CharV,    pair: 1'b1, rep: 1'b0};
      4'd12:   w = '{weight: 10'd1,    sym_a: CharI, sym_b: CharNone, pair: 1'b0, rep: 1'b1};
      default: w = '{weight: 10'd1,    sym_a: CharI, sym_b: CharNone, pair: 1'b0, rep: 1'b1};
    endcase
    return w;
  endfunction

endpackage

>>> sv/i2r_seq.sv
module i2r_seq import i2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  input  logic              adv_i,
  output logic              busy_o,
  output logic              emit_o,
  output char_t             char_o
);

  logic              busy_q, busy_d;
  logic              zero_q, zero_d;
  logic              half_q, half_d;
  logic [PcW-1:0]    pc_q, pc_d;
  logic [ValueW-1:0] rem_q, rem_d;

  ucode_t            word;
  logic [ValueW-1:0] weight_ext;
  logic [ValueW-1:0] rem_sub;
  logic              hit;

  assign word       = i2r_rom(pc_q);
  assign weight_ext = {{(ValueW-WeightW){1'b0}}, word.weight};
  assign hit        = rem_q >= weight_ext;
  assign rem_sub    = rem_q - weight_ext;

  always_comb begin
    busy_d = busy_q;
    zero_d = zero_q;
    half_d = half_q;
    pc_d   = pc_q;
    rem_d  = rem_q;
    emit_o = 1'b0;
    char_o = '{symbol: CharNone, is_empty: 1'b0, last: 1'b0};
    if (start_i) begin
      busy_d = 1'b1;
      zero_d = (value_i == '0);
      half_d = 1'b0;
      pc_d   = '0;
      rem_d  = value_i;
    end else if (busy_q) begin
      if (zero_q) begin
        char_o = '{symbol: CharNone, is_empty: 1'b1, last: 1'b1};
        emit_o = adv_i;
        if (adv_i) begin
          busy_d = 1'b0;
          zero_d = 1'b0;
        end
      end else if (half_q) begin
        char_o = '{symbol: word.sym_b, is_empty: 1'b0, last: (rem_q == '0)};
        emit_o = adv_i;
        if (adv_i) begin
          half_d = 1'b0;
          pc_d   = pc_q + 1'b1;
          busy_d = (rem_q != '0);
        end
      end else if (hit) begin
        char_o = '{symbol: word.sym_a, is_empty: 1'b0,
                   last: !word.pair && (rem_sub == '0)};
        emit_o = adv_i;
        if (adv_i) begin
          rem_d = rem_sub;
          if (word.pair) begin
            half_d = 1'b1;
          end else begin
            busy_d = (rem_sub != '0);
            if (!word.rep) begin
              pc_d = pc_q + 1'b1;
            end
          end
        end
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      zero_q <= 1'b0;
      half_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      zero_q <= zero_d;
      half_q <= half_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;

endmodule

>>> sv/integer_to_roman_numeral.sv
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   value_i
// output    out        out_valid_o / out_stall_i symbol_o, is_empty_o, last_o
//
// One request is converted at a time; a new one is taken the cycle after the
// previous numeral's last character has entered the output register.
// The sequencer steps a 13-row control table, one row or one character per
// cycle; a character waits while the output is stalled.
// A zero request gives one character flagged empty.
// Reset clears the sequencer's control state and the output valid; no clearing pass is needed.
`include "integer_to_roman_numeral_defines.svh"

module integer_to_roman_numeral import i2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SymW-1:0]   symbol_o,
  output logic              is_empty_o,
  output logic              last_o
);

  logic  busy;
  logic  start;
  logic  adv;
  logic  emit;
  char_t char_s;

  logic  out_valid_q, out_valid_d;
  char_t out_char_q;

  assign start = in_valid_i && !busy;
  assign adv   = !out_valid_q || !out_stall_i;

  i2r_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (value_i),
    .adv_i   (adv),
    .busy_o  (busy),
    .emit_o  (emit),
    .char_o  (char_s)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= char_s;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_char_q.symbol;
  assign is_empty_o  = out_char_q.is_empty;
  assign last_o      = out_char_q.last;

  `I2R_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `I2R_ASSERT_NEXT(a_idle_after_last, emit && char_s.last, !in_stall_o)
  `I2R_ASSERT_SAME(a_emit_needs_room, emit, adv && in_stall_o)
  `I2R_ASSERT_SAME(a_empty_is_last, out_valid_o && is_empty_o,
                   last_o && (symbol_o == CharNone))

endmodule
